/* design/ffba_pkg.sv */
// Shared types, constants and codes of the first-fit block allocator.
package ffba_pkg;

   localparam int HEAP_BYTES   = 1024 * 1024;
   localparam int HEADER_BYTES = 16;
   localparam int MAX_BLOCKS   = 64;

   localparam int ADDR_W = 20;
   localparam int REQ_W  = 21;
   localparam int TOT_W  = 22;
   localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NOFIT   = 2'd1,
      ST_UNKNOWN = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   typedef enum logic {
      FUNC_ALLOC = 1'b0,
      FUNC_FREE  = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      CELL_HOLD        = 2'd0,
      CELL_ALLOC       = 2'd1,
      CELL_ALLOC_SPLIT = 2'd2,
      CELL_FREE        = 2'd3
   } cell_op_type;

   typedef enum logic {
      FSM_IDLE  = 1'b0,
      FSM_APPLY = 1'b1
   } fsm_type;

   typedef struct packed {
      logic                     func;
      logic [REQ_W-1:0]         request_bytes;
      logic [ADDR_W-1:0]        payload_offset;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic [ADDR_W-1:0]        result_offset;
   } rsp_type;

   typedef struct packed {
      logic                     valid;
      logic                     free;
      logic [ADDR_W-1:0]        start;
      logic [ADDR_W-1:0]        size;
   } entry_type;

   typedef struct packed {
      logic                     load;
      cell_op_type              op;
      logic [TOT_W-1:0]         total;
      logic [ADDR_W-1:0]        offset;
   } cell_cmd_type;

   typedef struct packed {
      entry_type                entry;
      logic [ADDR_W-1:0]        rem_start;
      logic [ADDR_W-1:0]        rem_size;
      logic                     prior;
      logic                     first;
   } link_type;

   typedef struct packed {
      logic                     valid;
      logic                     first;
      logic                     split;
      logic                     match;
      logic [ADDR_W-1:0]        start;
   } cell_stat_type;

endpackage

/* design/ffba_cell.sv */
// One table cell: holds a block entry, flags fit and match, shifts on a split.
module ffba_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  ffba_pkg::entry_type    init_entry,
   input  ffba_pkg::cell_cmd_type cmd,
   input  ffba_pkg::link_type     link_in,
   output ffba_pkg::link_type     link_out,
   output ffba_pkg::cell_stat_type stat
);
   import ffba_pkg::*;

   localparam logic [TOT_W-1:0] HDR_T = TOT_W'(HEADER_BYTES);

   entry_type        entry_ff, entry_in;
   logic             hit_ff, hit_in;
   logic             match_ff, match_in;
   logic             split_ff, split_in;
   logic             upstream;
   logic             first;
   logic [TOT_W-1:0] size_ext;
   logic [TOT_W-1:0] start_ext;
   logic [TOT_W-1:0] total_hdr;
   logic [TOT_W-1:0] rem_start;
   logic [TOT_W-1:0] rem_size;

   assign size_ext  = TOT_W'(entry_ff.size);
   assign start_ext = TOT_W'(entry_ff.start);
   assign total_hdr = cmd.total + HDR_T;
   assign rem_start = start_ext + total_hdr;
   assign rem_size  = size_ext - total_hdr;

   assign upstream = link_in.prior | link_in.first;
   assign first    = hit_ff & ~upstream;

   always_comb begin
      hit_in   = hit_ff;
      match_in = match_ff;
      split_in = split_ff;
      if (cmd.load) begin
         hit_in   = entry_ff.valid & entry_ff.free & (size_ext >= cmd.total);
         split_in = size_ext > total_hdr;
         match_in = entry_ff.valid & ((start_ext + HDR_T) == TOT_W'(cmd.offset));
      end
   end

   always_comb begin
      entry_in = entry_ff;
      case (cmd.op)
         CELL_ALLOC: begin
            if (first) begin
               entry_in.free = 1'b0;
            end
         end
         CELL_ALLOC_SPLIT: begin
            if (first) begin
               entry_in.free = 1'b0;
               entry_in.size = cmd.total[ADDR_W-1:0];
            end else if (link_in.first) begin
               entry_in.valid = 1'b1;
               entry_in.free  = 1'b1;
               entry_in.start = link_in.rem_start;
               entry_in.size  = link_in.rem_size;
            end else if (link_in.prior) begin
               entry_in = link_in.entry;
            end
         end
         CELL_FREE: begin
            if (match_ff) begin
               entry_in.free = 1'b1;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= init_entry;
         hit_ff   <= 1'b0;
         match_ff <= 1'b0;
         split_ff <= 1'b0;
      end else begin
         entry_ff <= entry_in;
         hit_ff   <= hit_in;
         match_ff <= match_in;
         split_ff <= split_in;
      end
   end

   assign link_out.entry     = entry_ff;
   assign link_out.rem_start = rem_start[ADDR_W-1:0];
   assign link_out.rem_size  = rem_size[ADDR_W-1:0];
   assign link_out.prior     = upstream;
   assign link_out.first     = first;

   assign stat.valid = entry_ff.valid;
   assign stat.first = first;
   assign stat.split = split_ff;
   assign stat.match = match_ff;
   assign stat.start = entry_ff.start;

endmodule

/* design/first_fit_block_allocator_top.sv */
// Top level of the first-fit block allocator: cell row, control and result register.
//
//   channel | ports                  | handshake
//   --------+------------------------+-----------------------------------------
//   request | start, busy, req_data  | taken at a clock edge with start && !busy
//   result  | rsp_valid, rsp_data    | one-cycle strobe, always taken
//
// On the accept edge every cell loads its fit and match flags. In the apply state the
// control picks the first fit along the cell row (for a free, the matching block),
// updates the row (shift on split) and registers the result; busy is high in that state.
// Reset leaves one free block covering the heap; no clearing pass is needed.
// The result strobe comes in the cycle after busy and cannot be held off.
module first_fit_block_allocator_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ffba_pkg::req_type req_data,
   output logic              rsp_valid,
   output ffba_pkg::rsp_type rsp_data
);
   import ffba_pkg::*;

   localparam logic [TOT_W-1:0]  HDR_T = TOT_W'(HEADER_BYTES);
   localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(MAX_BLOCKS);

   fsm_type           state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              func_ff;
   logic [ADDR_W-1:0] offset_ff;
   logic [TOT_W-1:0]  total_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic              accept;
   logic [TOT_W-1:0]  req_total;
   cell_cmd_type      cmd;
   cell_op_type       op;

   link_type          links [MAX_BLOCKS+1];
   cell_stat_type     stats [MAX_BLOCKS];
   logic [MAX_BLOCKS-1:0] valid_vec;
   logic [MAX_BLOCKS-1:0] first_vec;
   logic              any_fit;
   logic              any_match;
   logic              sel_split;
   logic [ADDR_W-1:0] sel_start;
   logic [TOT_W-1:0]  sel_offset;

   assign accept    = start & (state_ff == FSM_IDLE);
   assign req_total = TOT_W'(req_data.request_bytes) + HDR_T;

   assign cmd.load   = accept;
   assign cmd.op     = op;
   assign cmd.total  = (state_ff == FSM_IDLE) ? req_total : total_ff;
   assign cmd.offset = req_data.payload_offset;

   assign links[0] = '0;

   for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
      entry_type init_entry;
      if (i == 0) begin : g_head
         assign init_entry = '{valid: 1'b1, free: 1'b1, start: '0,
                               size: ADDR_W'(HEAP_BYTES - HEADER_BYTES)};
      end else begin : g_rest
         assign init_entry = '0;
      end
      ffba_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .init_entry (init_entry),
         .cmd        (cmd),
         .link_in    (links[i]),
         .link_out   (links[i+1]),
         .stat       (stats[i])
      );
   end

   always_comb begin
      any_fit   = 1'b0;
      any_match = 1'b0;
      sel_split = 1'b0;
      sel_start = '0;
      for (int i = 0; i < MAX_BLOCKS; i++) begin
         valid_vec[i] = stats[i].valid;
         first_vec[i] = stats[i].first;
         any_fit      = any_fit | stats[i].first;
         any_match    = any_match | stats[i].match;
         sel_split    = sel_split | (stats[i].first & stats[i].split);
         sel_start    = sel_start | (stats[i].first ? stats[i].start : '0);
      end
   end

   assign sel_offset = TOT_W'(sel_start) + HDR_T;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      op           = CELL_HOLD;
      rsp_valid_in = 1'b0;
      rsp_in       = '{status: ST_OK, result_offset: '0};
      unique case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               state_in = FSM_APPLY;
            end
         end
         FSM_APPLY: begin
            state_in     = FSM_IDLE;
            rsp_valid_in = 1'b1;
            if (func_ff == FUNC_ALLOC) begin
               if (!any_fit) begin
                  rsp_in.status = ST_NOFIT;
               end else if (sel_split && (count_ff == FULL_COUNT)) begin
                  rsp_in.status = ST_FULL;
               end else begin
                  rsp_in.result_offset = sel_offset[ADDR_W-1:0];
                  if (sel_split) begin
                     op       = CELL_ALLOC_SPLIT;
                     count_in = count_ff + CNT_W'(1);
                  end else begin
                     op = CELL_ALLOC;
                  end
               end
            end else if (offset_ff != '0) begin
               if (any_match) begin
                  op = CELL_FREE;
               end else begin
                  rsp_in.status = ST_UNKNOWN;
               end
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= CNT_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (accept) begin
         func_ff   <= req_data.func;
         offset_ff <= req_data.payload_offset;
         total_ff  <= req_total;
      end
   end

   assign busy      = (state_ff == FSM_APPLY);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_rsp_after_apply: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == FSM_APPLY))
      else $error("result strobe without an apply cycle");

   a_count_matches_row: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(count_ff))
      else $error("block count disagrees with valid cells");

   a_single_pick: assert property (@(posedge clock) disable iff (reset)
      $onehot0(first_vec))
      else $error("more than one cell picked");

   a_fail_no_offset: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status != ST_OK)) |-> (rsp_ff.result_offset == '0))
      else $error("failed request carries an offset");

endmodule
